// File: design/rlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants of the RMS level meter
// Field widths, fixed-point constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int LEVEL_W         = 16;
  localparam int MS_W            = 31;
  localparam int ALPHA_W         = 16;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int MAG_W           = 17;
  localparam int PROD_W          = MAG_W + MS_W;
  localparam int ROOT_W          = 32;
  localparam int ROOT_STEPS      = 16;
  localparam int CNT_W           = 4;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'hFFFF;
  localparam logic [PROD_W-1:0]  ALPHA_HALF    = 48'h0000_0000_8000;
  localparam logic [MS_W-1:0]    ROOT_BIT_INIT = 31'h4000_0000;
  localparam logic [MS_W-1:0]    MS_MAX        = 31'h4000_0000;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b000_0001,
    ST_SQUARE = 7'b000_0010,
    ST_DIFF   = 7'b000_0100,
    ST_SCALE  = 7'b000_1000,
    ST_UPDATE = 7'b001_0000,
    ST_ROOT   = 7'b010_0000,
    ST_DONE   = 7'b100_0000
  } rlm_state_t;

endpackage

// File: design/rlm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlm_in_if: sample channel
// Valid/ready channel carrying one signed Q1.15 audio sample.
// ----------------------------------------------------------------------------
interface rlm_in_if import rlm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// File: design/rlm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlm_out_if: level channel
// Valid/ready channel carrying the RMS level and the updated mean square.
// ----------------------------------------------------------------------------
interface rlm_out_if import rlm_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] rms_level;
  logic [MS_W-1:0]    mean_square;

  modport source (output valid, output rms_level, output mean_square, input ready);
  modport sink   (input valid, input rms_level, input mean_square, output ready);

endinterface

// File: design/rlm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlm_mul: shared registered multiplier
// 17 x 31 bit unsigned product, registered; used for the square and the
// alpha scaling.
// ----------------------------------------------------------------------------
module rlm_mul import rlm_pkg::*; (
  input  logic              clk,
  input  logic [MAG_W-1:0]  a_i,
  input  logic [MS_W-1:0]   b_i,
  output logic [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_r;

endmodule

// File: design/rms_level_meter_core.sv
`timescale 1ns / 1ps
// Each sample runs through the square, difference, scale, update, root and
// done states; no new sample is taken until they are through, as the
// sequencer runs the shared multiplier twice and the 16 iterations of the
// bitwise square root. Input is taken in idle only; a pending result waits in the output register.
// Reset (synchronous, rst_n low): mean square cleared, weight set to 65535.
// ----------------------------------------------------------------------------
// rms_level_meter_core: exponential moving average RMS level meter
// Squares each sample, moves the mean square toward it by alpha, and
// returns the floor square root as the RMS level.
// ----------------------------------------------------------------------------
module rms_level_meter_core import rlm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rlm_in_if.sink             in_chan,
  rlm_out_if.source          out_chan,
  input  logic               cfg_we,
  input  logic [ALPHA_W-1:0] cfg_wdata
);

  rlm_state_t          state_r, state_nxt;
  logic [ALPHA_W-1:0]  alpha_r;
  logic [MS_W-1:0]     ema_r, ema_nxt;
  logic [MAG_W-1:0]    mag_r;
  logic [MS_W-1:0]     d_r;
  logic                ge_r;
  logic [MS_W-1:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [MS_W-1:0]     bit_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  rms_level_r;
  logic [MS_W-1:0]     mean_square_r;

  logic [MAG_W-1:0]    mul_a;
  logic [MS_W-1:0]     mul_b;
  logic [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]    samp_ext;
  logic [MAG_W-1:0]    mag_in;
  logic [MS_W-1:0]     sq;
  logic [MS_W-1:0]     step;
  logic [ROOT_W-1:0]   trial;
  logic                take;
  logic                in_fire;
  logic                out_load;

  rlm_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  assign samp_ext = {in_chan.sample[SAMPLE_W-1], in_chan.sample};
  assign mag_in   = samp_ext[MAG_W-1] ? MAG_W'(~samp_ext + 1'b1) : samp_ext;

  // Scale step multiplies alpha by the difference; otherwise square the sample
  assign mul_a = (state_r == ST_SCALE) ? {1'b0, alpha_r} : mag_r;
  assign mul_b = (state_r == ST_SCALE) ? d_r : MS_W'(mag_r);

  assign sq    = prod[MS_W-1:0];
  assign step  = MS_W'((prod + ALPHA_HALF) >> ALPHA_FRAC_BITS);
  assign ema_nxt = ge_r ? MS_W'(ema_r + step) : MS_W'(ema_r - step);

  assign trial = root_r + ROOT_W'(bit_r);
  assign take  = ROOT_W'(rem_r) >= trial;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_ROOT;
      ST_ROOT:   if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_r     <= ALPHA_RESET;
      ema_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) alpha_r <= cfg_wdata;
      if (state_r == ST_UPDATE) ema_r <= ema_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) mag_r <= mag_in;
    if (state_r == ST_DIFF) begin
      ge_r <= (sq >= ema_r);
      d_r  <= (sq >= ema_r) ? MS_W'(sq - ema_r) : MS_W'(ema_r - sq);
    end
    if (state_r == ST_UPDATE) begin
      rem_r  <= ema_nxt;
      root_r <= '0;
      bit_r  <= ROOT_BIT_INIT;
      cnt_r  <= '0;
    end
    if (state_r == ST_ROOT) begin
      // Restoring square root: one result bit per iteration
      if (take) begin
        rem_r  <= MS_W'(ROOT_W'(rem_r) - trial);
        root_r <= (root_r >> 1) + ROOT_W'(bit_r);
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
    end
    if (out_load) begin
      rms_level_r   <= root_r[LEVEL_W-1:0];
      mean_square_r <= ema_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.rms_level   = rms_level_r;
  assign out_chan.mean_square = mean_square_r;

`ifndef SYNTHESIS
  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    ema_r <= MS_MAX)
    else $error("mean square above 2^30");

  a_ema_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_UPDATE |=> $stable(ema_r))
    else $error("mean square changed outside update");

  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (34'(rms_level_r) * 34'(rms_level_r) <= 34'(mean_square_r)) &&
                    ((34'(rms_level_r) + 34'd1) * (34'(rms_level_r) + 34'd1) >
                     34'(mean_square_r)))
    else $error("rms level is not the floor square root");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_SQUARE && mag_r <= MAG_W'(32768))
    else $error("sample transaction did not start the sequence");
`endif

endmodule

// File: tb/rms_level_meter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_level_meter_core_tb: self-checking bench for the RMS level meter
// Drives signed samples through the valid/ready channel, tracks the running
// mean square in a fixed-point predictor and checks both output fields of
// every result. Covers weight extremes, full-scale samples and back-pressure.
// ----------------------------------------------------------------------------
module rms_level_meter_core_tb import rlm_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [MS_W-1:0]    mean_square;
  } level_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ALPHA_W-1:0] cfg_wdata;

  rlm_in_if  in_chan ();
  rlm_out_if out_chan ();

  rms_level_meter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic [ALPHA_W-1:0] model_weight;
  logic [MS_W-1:0]    model_mean_square;
  level_result_t      expected_levels[$];

  int err_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] floor_root(input logic [MS_W-1:0] v);
    logic [16:0] root;
    logic [16:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (17'd1 << i);
      if (64'(trial) * 64'(trial) <= 64'(v))
        root = trial;
    end
    return root[LEVEL_W-1:0];
  endfunction

  // Square the sample and move the mean square toward it by the weight.
  function automatic level_result_t predict_level(input logic signed [SAMPLE_W-1:0] s);
    logic [16:0]     mag;
    logic [31:0]     sq;
    logic [31:0]     ema;
    logic [31:0]     diff;
    logic [63:0]     delta;
    level_result_t   r;
    mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    sq  = 32'(mag) * 32'(mag);
    ema = {1'b0, model_mean_square};
    diff = (sq >= ema) ? sq - ema : ema - sq;
    delta = (64'(model_weight) * 64'(diff) + 64'd32768) >> ALPHA_FRAC_BITS;
    if (sq >= ema)
      ema = ema + delta[31:0];
    else
      ema = ema - delta[31:0];
    model_mean_square = ema[MS_W-1:0];
    r.mean_square = model_mean_square;
    r.rms_level   = floor_root(model_mean_square);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Offer one sample, hold it until the transaction, then drop valid.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk);
    in_chan.valid  = 1'b1;
    in_chan.sample = s;
    @(posedge clk);
    while (!in_chan.ready)
      @(posedge clk);
    expected_levels.push_back(predict_level(s));
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_levels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_weight(input logic [ALPHA_W-1:0] w);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 1'b0;
    model_weight = w;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] shaped_sample(input int kind);
    logic [SAMPLE_W-1:0] v;
    case (kind)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(255)) ^ ($urandom_range(1) ? 16'hFFFF : 16'h0000);
      2: v = $urandom_range(1) ? 16'(32767 - $urandom_range(63))
                              : 16'(-32768 + $urandom_range(63));
      default: v = 16'($urandom_range(4095)) - 16'd2048;
    endcase
    return v;
  endfunction

  // Send bursts of one flavor: noise, small, near full scale, mid-level or a held level.
  task automatic send_random_items(input int count);
    int kind;
    int run;
    logic signed [SAMPLE_W-1:0] held;
    while (count > 0) begin
      kind = $urandom_range(4);
      run  = $urandom_range(40, 1);
      held = 16'($urandom);
      for (int i = 0; i < run && count > 0; i++) begin
        send_sample(kind == 4 ? held : shaped_sample(kind));
        count--;
      end
    end
  endtask

  task automatic test_reset_weight();
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd32767);
  endtask

  task automatic test_weight_extremes();
    // Zero weight: mean square must hold.
    write_weight(16'd0);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd12345);
    // Tiny weight: steps that round to zero leave the mean square unchanged.
    write_weight(16'd1);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(16'sd181);
    send_sample(-16'sd32768);
    write_weight(16'd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd3);
    write_weight(16'hFFFF);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd2);
  endtask

  task automatic test_idle_phases();
    logic [ALPHA_W-1:0] weights[8];
    weights = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                16'h5555, 16'hAAAA, 16'h0000, 16'h0000};
    weights[6] = 16'($urandom);
    weights[7] = 16'($urandom_range(2047));
    for (int p = 0; p < 8; p++) begin
      write_weight(weights[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      send_random_items(250);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_holdoff();
    write_weight(16'h4000);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++)
      send_sample(shaped_sample(0));
    // Pause the sender until every result is out.
    wait_drained();
    recv_stall_pct = 30;
    send_random_items(40);
    wait_drained();
    recv_stall_pct = 0;
  endtask

  // Receiver: long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_chan.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_chan.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    level_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result level=%0d ms=%0d",
                                  out_chan.rms_level, out_chan.mean_square));
      end else begin
        want = expected_levels.pop_front();
        if (out_chan.mean_square !== want.mean_square)
          report_mismatch($sformatf("mean_square got %0d exp %0d",
                                    out_chan.mean_square, want.mean_square));
        if (out_chan.rms_level !== want.rms_level)
          report_mismatch($sformatf("rms_level got %0d exp %0d",
                                    out_chan.rms_level, want.rms_level));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_levels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    out_chan.ready = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    model_weight      = ALPHA_RESET;
    model_mean_square = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_weight();
    test_weight_extremes();
    test_idle_phases();
    test_output_holdoff();

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
design/rlm_pkg.sv
design/rlm_in_if.sv
design/rlm_out_if.sv
design/rlm_mul.sv
design/rms_level_meter_core.sv
tb/rms_level_meter_core_tb.sv
